[hw/rtl/ptg_pkg.sv]
package ptg_pkg;

    // field and datapath widths
    localparam int FREQ_W      = 16;
    localparam int DUR_W       = 16;
    localparam int CLOCK_W     = 25;
    localparam int VOL_W       = 2;
    localparam int KIND_W      = 2;
    localparam int PROD_W      = FREQ_W + DUR_W;
    localparam int DIVIDEND_W  = 32;
    localparam int DIVISOR_W   = 16;
    localparam int DIV_CNT_W   = 5;
    localparam int MUL_CNT_W   = 5;
    localparam int EVENT_W     = 24;
    localparam int PRESC_W     = 10;
    localparam int SHIFT_W     = 4;
    localparam int SHIFT_IDX_W = 3;
    localparam int NUM_SHIFTS  = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 25;

    // word kinds
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_VOLUME = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOCK  = 1'd1;

    // volume codes
    localparam logic [VOL_W-1:0] VOL_SILENT = 2'd0;
    localparam logic [VOL_W-1:0] VOL_SINGLE = 2'd1;
    localparam logic [VOL_W-1:0] VOL_BOTH   = 2'd2;

    localparam logic [CLOCK_W-1:0]   CLOCK_RESET   = 25'd16000000;
    localparam logic [DIVISOR_W-1:0] COUNT_DIVISOR = 16'd500;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_CLK,
        ST_DIV_CNT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [FREQ_W-1:0] tone_frequency;
        logic [DUR_W-1:0]  duration_ms;
    } in_word_t;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic playing;
        logic start_rejected;
    } out_word_t;

    typedef struct packed {
        logic                  load;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    // prescale shift candidates, smallest first
    function automatic logic [SHIFT_W-1:0] prescale_shift_of(input logic [SHIFT_IDX_W-1:0] idx);
        logic [SHIFT_W-1:0] s;
        case (idx)
            3'd0:    s = 4'd0;
            3'd1:    s = 4'd3;
            3'd2:    s = 4'd5;
            3'd3:    s = 4'd6;
            3'd4:    s = 4'd7;
            3'd5:    s = 4'd8;
            3'd6:    s = 4'd10;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

[hw/rtl/ptg_serial_div.sv]
module ptg_serial_div
    import ptg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  diff;
    logic                  fits;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dsr_reg};
        fits      = !diff[DIVISOR_W+1];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[hw/rtl/piezo_tone_generator_unit.sv]
// square-wave tone generator for a two-pin piezo. each input word is a start request, a stop
// request or one tick of the input clock, and each gives exactly one output word with the pin
// levels, the playing flag and, for a start, whether the frequency was out of reach. tick and
// stop words may follow every cycle, but a new word is taken only while the block is idle and
// the output register is empty or being read in that same cycle. a start with a nonzero
// frequency holds the input while a bit-serial divider finds clock_hz / tone_frequency in 32
// steps; once it reports done, the same divider takes duration_ms * tone_frequency (built by
// a 16-step shift-add multiplier meanwhile) over 500 in another 32 steps. the event count is
// then latched; once the output slot is free, the prescale shift is picked and the timer loaded.
// a zero-frequency start just stops the tone. the user must write configuration only while idle
// (volume_level, clock_hz, via cfg_we / cfg_index / cfg_data); the block does not enforce this
module piezo_tone_generator_unit
    import ptg_pkg::*;
#(
    parameter int TIMER_BITS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_word
);

    // a shifted quotient q gives half-rounded ticks (q+1)>>1, which fits the timer
    // exactly when q <= 2^(TIMER_BITS+1)
    localparam logic [CLOCK_W-1:0] TICK_LIMIT = CLOCK_W'(1) << (TIMER_BITS + 1);

    state_t                  state_reg, state_next;

    // configuration
    logic [VOL_W-1:0]        vol_reg, vol_next;
    logic [CLOCK_W-1:0]      clock_reg, clock_next;

    // tone state
    logic                    active_reg, active_next;
    logic [1:0]              pins_reg, pins_next;
    logic [SHIFT_W-1:0]      shift_reg, shift_next;
    logic [PRESC_W-1:0]      presc_reg, presc_next;
    logic [TIMER_BITS-1:0]   timer_reg, timer_next;
    logic [TIMER_BITS-1:0]   top_reg, top_next;
    logic [EVENT_W-1:0]      events_reg, events_next;

    // shift-add multiplier
    logic [MUL_CNT_W-1:0]    mul_left_reg, mul_left_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [FREQ_W-1:0]       mcand_reg, mcand_next;
    logic [FREQ_W:0]         mul_sum;

    // start results
    logic [CLOCK_W-1:0]      q_reg, q_next;
    logic [EVENT_W-1:0]      count_reg, count_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    out_word_t               out_word_reg, out_word_next;

    div_req_t                div_req;
    div_rsp_t                div_rsp;

    logic                    slot_free;
    logic                    in_fire;
    logic                    produce;
    logic                    rejected;
    logic [PRESC_W-1:0]      pmask;
    logic [PRESC_W-1:0]      presc_inc;
    logic [EVENT_W-1:0]      ev_dec;
    logic                    found;
    logic [CLOCK_W-1:0]      sel_q;
    logic [SHIFT_W-1:0]      sel_shift;
    logic [TIMER_BITS-1:0]   top_calc;

    ptg_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // output slot frees up when empty or being taken this cycle
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign in_fire   = in_valid && in_ready;

    // prescaler period is 2^shift
    assign pmask     = PRESC_W'((11'd1 << shift_reg) - 11'd1);
    assign presc_inc = (presc_reg + 1'b1) & pmask;
    assign ev_dec    = events_reg - 1'b1;
    assign mul_sum   = {1'b0, prod_reg[PROD_W-1:DUR_W]} +
                       (prod_reg[0] ? {1'b0, mcand_reg} : '0);

    // pick the smallest prescale shift whose tick count fits the timer
    always_comb
    begin
        found     = 1'b0;
        sel_q     = '0;
        sel_shift = '0;
        for (int i = NUM_SHIFTS - 1; i >= 0; i--)
        begin
            if ((q_reg >> prescale_shift_of(SHIFT_IDX_W'(i))) <= TICK_LIMIT)
            begin
                found     = 1'b1;
                sel_q     = q_reg >> prescale_shift_of(SHIFT_IDX_W'(i));
                sel_shift = prescale_shift_of(SHIFT_IDX_W'(i));
            end
        end
        // top = ticks - 1, with a rounded tick count of zero treated as one
        top_calc = (sel_q == '0) ? '0 : TIMER_BITS'((sel_q - CLOCK_W'(1)) >> 1);
    end

    always_comb
    begin
        state_next     = state_reg;
        vol_next       = vol_reg;
        clock_next     = clock_reg;
        active_next    = active_reg;
        pins_next      = pins_reg;
        shift_next     = shift_reg;
        presc_next     = presc_reg;
        timer_next     = timer_reg;
        top_next       = top_reg;
        events_next    = events_reg;
        mul_left_next  = mul_left_reg;
        prod_next      = prod_reg;
        mcand_next     = mcand_reg;
        q_next         = q_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        produce        = 1'b0;
        rejected       = 1'b0;

        div_req.load     = 1'b0;
        div_req.dividend = {{(DIVIDEND_W - CLOCK_W){1'b0}}, clock_reg};
        div_req.divisor  = in_word.tone_frequency;

        // configuration writes, volume saturates at both pins
        if (cfg_we)
        begin
            case (cfg_index)
                REG_VOLUME: vol_next = (cfg_data[VOL_W-1:0] > VOL_BOTH) ?
                                       VOL_BOTH : cfg_data[VOL_W-1:0];
                REG_CLOCK:  clock_next = cfg_data[CLOCK_W-1:0];
                default:    ;
            endcase
        end

        // multiplier runs in the background during the first divide
        if (mul_left_reg != '0)
        begin
            prod_next     = {mul_sum, prod_reg[DUR_W-1:1]};
            mul_left_next = mul_left_reg - 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_word.kind)
                        KIND_START:
                        begin
                            // any running tone stops first
                            active_next = 1'b0;
                            pins_next   = 2'b00;
                            if (in_word.tone_frequency == '0)
                            begin
                                produce = 1'b1;
                            end
                            else
                            begin
                                div_req.load  = 1'b1;
                                prod_next     = {{FREQ_W{1'b0}}, in_word.duration_ms};
                                mcand_next    = in_word.tone_frequency;
                                mul_left_next = MUL_CNT_W'(DUR_W);
                                state_next    = ST_DIV_CLK;
                            end
                        end
                        KIND_STOP:
                        begin
                            active_next = 1'b0;
                            pins_next   = 2'b00;
                            produce     = 1'b1;
                        end
                        KIND_TICK:
                        begin
                            produce = 1'b1;
                            if (active_reg)
                            begin
                                presc_next = presc_inc;
                                if (presc_inc == '0)
                                begin
                                    if (timer_reg != top_reg)
                                    begin
                                        timer_next = timer_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        // compare event
                                        timer_next  = '0;
                                        events_next = ev_dec;
                                        if (ev_dec == '0)
                                        begin
                                            active_next = 1'b0;
                                            pins_next   = 2'b00;
                                        end
                                        else
                                        begin
                                            pins_next[0] = ev_dec[0] && (vol_reg >= VOL_SINGLE);
                                            pins_next[1] = !ev_dec[0] && (vol_reg >= VOL_BOTH);
                                        end
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            produce = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV_CLK:
            begin
                if (div_rsp.done)
                begin
                    q_next           = div_rsp.quotient[CLOCK_W-1:0];
                    div_req.load     = 1'b1;
                    div_req.dividend = prod_reg;
                    div_req.divisor  = COUNT_DIVISOR;
                    state_next       = ST_DIV_CNT;
                end
            end
            ST_DIV_CNT:
            begin
                if (div_rsp.done)
                begin
                    count_next = div_rsp.quotient[EVENT_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    produce    = 1'b1;
                    state_next = ST_IDLE;
                    if (found)
                    begin
                        shift_next  = sel_shift;
                        top_next    = top_calc;
                        presc_next  = '0;
                        timer_next  = '0;
                        events_next = count_reg;
                        active_next = (count_reg != '0);
                    end
                    else
                    begin
                        rejected = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (produce)
        begin
            out_valid_next              = 1'b1;
            out_word_next.pin_a          = pins_next[0];
            out_word_next.pin_b          = pins_next[1];
            out_word_next.playing        = active_next;
            out_word_next.start_rejected = rejected;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg       <= VOL_BOTH;
            clock_reg     <= CLOCK_RESET;
            active_reg    <= 1'b0;
            pins_reg      <= 2'b00;
            shift_reg     <= '0;
            presc_reg     <= '0;
            timer_reg     <= '0;
            top_reg       <= '0;
            events_reg    <= '0;
            mul_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vol_reg       <= vol_next;
            clock_reg     <= clock_next;
            active_reg    <= active_next;
            pins_reg      <= pins_next;
            shift_reg     <= shift_next;
            presc_reg     <= presc_next;
            timer_reg     <= timer_next;
            top_reg       <= top_next;
            events_reg    <= events_next;
            mul_left_reg  <= mul_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        mcand_reg    <= mcand_next;
        q_reg        <= q_next;
        count_reg    <= count_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // a playing tone always has events left to count
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (events_reg != '0))
        else $error("tone active with no events left");

    // the timer never runs past its compare value while playing
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (timer_reg <= top_reg))
        else $error("timer beyond compare top");

    // prescaler stays inside its period
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ((presc_reg & ~pmask) == '0))
        else $error("prescaler outside its period");

    // a rejected start never reports a playing tone
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.start_rejected) |-> !out_word_reg.playing)
        else $error("rejected start reported as playing");

endmodule

[dv/piezo_tone_generator_unit_test.sv]
module piezo_tone_generator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptg_pkg::*;

    // kind code that the block has no use for
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // timer span for TIMER_BITS = 8
    localparam int unsigned TIMER_SPAN = 256;

    // run length guards: starts are the slowest words, receiver stalls stretch every word
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 70;
    localparam int NUM_PHASES    = 6;

    // prescale shifts tried in order, smallest first
    localparam logic [SHIFT_W-1:0] SHIFT_CHOICES [NUM_SHIFTS] = '{0, 3, 5, 6, 7, 8, 10};

    // output words whose value is plain from the request alone (a, b, playing, rejected)
    localparam out_word_t OUT_IDLE     = 4'b0000;
    localparam out_word_t OUT_PLAYING  = 4'b0010;
    localparam out_word_t OUT_REJECTED = 4'b0001;
    localparam in_word_t  NO_WORD      = '0;

    // one line of the directed plan: either a register write or an input word
    typedef struct packed {
        logic                   is_reg;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        in_word_t               word;
        logic                   typed;
        out_word_t              want;
    } plan_row_t;

    localparam int PLAN_LEN = 30;

    localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        // reset settings: 16 MHz clock, both pins
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_TICK,   16'd0,     16'd0},     1'b1, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_STOP,   16'd0,     16'd0},     1'b1, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_UNUSED, 16'hFFFF,  16'hFFFF},  1'b1, OUT_IDLE},
        // zero frequency stays silent
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_START,  16'd0,     16'd65535}, 1'b1, OUT_IDLE},
        // lowest frequency cannot be reached even with the largest prescale
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_START,  16'd1,     16'd65535}, 1'b1, OUT_REJECTED},
        // zero event count
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_START,  16'd65535, 16'd0},     1'b1, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_START,  16'd65535, 16'd65535}, 1'b1, OUT_PLAYING},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_TICK,   16'hFFFF,  16'hFFFF},  1'b0, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_UNUSED, 16'd0,     16'd0},     1'b0, OUT_IDLE},
        // reach boundary at 16 MHz: 30 Hz just out of range, 31 Hz just inside
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_START,  16'd30,    16'd65535}, 1'b1, OUT_REJECTED},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_START,  16'd31,    16'd65535}, 1'b1, OUT_PLAYING},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_STOP,   16'd0,     16'd0},     1'b1, OUT_IDLE},
        // slow clock, frequency above it: rounded ticks of zero, event on every tick
        '{1'b1, REG_VOLUME, 25'd1,     NO_WORD,                          1'b0, OUT_IDLE},
        '{1'b1, REG_CLOCK,  25'd40000, NO_WORD,                          1'b0, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_START,  16'd65535, 16'd3},     1'b1, OUT_PLAYING},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_TICK,   16'd0,     16'd0},     1'b0, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_TICK,   16'd0,     16'd0},     1'b0, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_TICK,   16'd0,     16'd0},     1'b0, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_TICK,   16'd0,     16'd0},     1'b0, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_STOP,   16'd0,     16'd0},     1'b1, OUT_IDLE},
        // volume of three saturates to both pins
        '{1'b1, REG_VOLUME, 25'd3,     NO_WORD,                          1'b0, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_START,  16'd40000, 16'd1},     1'b1, OUT_PLAYING},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_TICK,   16'd0,     16'd0},     1'b0, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_TICK,   16'd0,     16'd0},     1'b0, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_STOP,   16'd0,     16'd0},     1'b1, OUT_IDLE},
        // fastest clock, silent volume: top of 255 at the smallest shift
        '{1'b1, REG_VOLUME, 25'd0,        NO_WORD,                       1'b0, OUT_IDLE},
        '{1'b1, REG_CLOCK,  25'd33554431, NO_WORD,                       1'b0, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_START,  16'd65535, 16'd1},     1'b1, OUT_PLAYING},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_TICK,   16'd0,     16'd0},     1'b0, OUT_IDLE},
        '{1'b0, REG_VOLUME, 25'd0, '{KIND_START,  16'd1,     16'd1},     1'b1, OUT_REJECTED}
    };

    // settings per random phase: extremes of both registers among them
    localparam logic [VOL_W-1:0]   PHASE_VOL   [NUM_PHASES] = '{2, 1, 3, 0, 2, 1};
    localparam logic [CLOCK_W-1:0] PHASE_CLOCK [NUM_PHASES] =
        '{40000, 1000000, 25000, 60000, 33554431, 30000};

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;

    // idling odds in percent, sender and receiver
    int idle_tx = 0;
    int idle_rx = 0;

    int cycles     = 0;
    int mismatches = 0;

    // output words still to come, oldest first
    out_word_t pending_outputs [$];

    // tone state mirrored from the block's behaviour
    logic                 tone_on;
    logic [SHIFT_W-1:0]   shift_sel;
    logic [PRESC_W-1:0]   presc_cnt;
    logic [7:0]           tmr;
    logic [7:0]           tmr_top;
    logic [EVENT_W-1:0]   events_rem;
    logic [1:0]           pins;
    logic [VOL_W-1:0]     vol_cfg;
    logic [CLOCK_W-1:0]   clk_cfg;

    piezo_tone_generator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard stop should the block hang
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[piezo_tone_generator_unit] ERROR");
            $finish;
        end
    end

    // receiver back-pressure, changed at the falling edge only
    always @(negedge clk)
    begin
        out_ready = rst_n && ($urandom_range(99) >= idle_rx);
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    // next output word of the tone generator; advances the mirrored state
    function automatic out_word_t next_pin_word(input in_word_t w);
        logic [31:0] q;
        logic [31:0] ticks;
        logic [31:0] prod;
        logic [10:0] pmask;
        logic        found;
        logic        rej;
        out_word_t   r;
        rej = 1'b0;
        case (w.kind)
            KIND_START:
            begin
                // any start silences the current tone first
                tone_on = 1'b0;
                pins    = 2'b00;
                if (w.tone_frequency != 0)
                begin
                    found = 1'b0;
                    for (int i = 0; i < NUM_SHIFTS; i++)
                    begin
                        q     = ({7'd0, clk_cfg} >> SHIFT_CHOICES[i]) / {16'd0, w.tone_frequency};
                        ticks = (q + 32'd1) >> 1;
                        if (!found && ticks <= TIMER_SPAN)
                        begin
                            // frequency above the clock rounds to zero ticks
                            if (ticks == 0)
                                ticks = 32'd1;
                            shift_sel = SHIFT_CHOICES[i];
                            tmr_top   = 8'(ticks - 32'd1);
                            found     = 1'b1;
                        end
                    end
                    if (!found)
                        rej = 1'b1;
                    else
                    begin
                        presc_cnt  = '0;
                        tmr        = '0;
                        prod       = {16'd0, w.duration_ms} * {16'd0, w.tone_frequency};
                        events_rem = EVENT_W'(prod / {16'd0, COUNT_DIVISOR});
                        tone_on    = (events_rem != 0);
                    end
                end
            end
            KIND_STOP:
            begin
                tone_on = 1'b0;
                pins    = 2'b00;
            end
            KIND_TICK:
            begin
                if (tone_on)
                begin
                    pmask     = (11'd1 << shift_sel) - 11'd1;
                    presc_cnt = (presc_cnt + 10'd1) & pmask[PRESC_W-1:0];
                    if (presc_cnt == 0)
                    begin
                        if (tmr != tmr_top)
                            tmr = tmr + 8'd1;
                        else
                        begin
                            // compare event
                            tmr        = '0;
                            events_rem = events_rem - 1'b1;
                            if (events_rem == 0)
                            begin
                                tone_on = 1'b0;
                                pins    = 2'b00;
                            end
                            else
                            begin
                                pins[0] = events_rem[0] && (vol_cfg >= VOL_SINGLE);
                                pins[1] = !events_rem[0] && (vol_cfg >= VOL_BOTH);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        r.pin_a          = pins[0];
        r.pin_b          = pins[1];
        r.playing        = tone_on;
        r.start_rejected = rej;
        return r;
    endfunction

    // present one word, hold it until taken, then queue what it should give
    task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
        out_word_t pred;
        @(negedge clk);
        while ($urandom_range(99) < idle_tx)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_word  = w;
        do
            @(posedge clk);
        while (!in_ready);
        pred = next_pin_word(w);
        pending_outputs.push_back(typed ? want : pred);
    endtask

    // drop valid, let every queued word arrive, then pause to settle
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_VOLUME)
            vol_cfg = (val[VOL_W-1:0] > VOL_BOTH) ? VOL_BOTH : val[VOL_W-1:0];
        else
            clk_cfg = val[CLOCK_W-1:0];
    endtask

    // mostly ticks, with starts shaped so that tones run out within a few dozen ticks
    function automatic in_word_t random_word();
        in_word_t    w;
        int unsigned pick;
        int unsigned k;
        int unsigned f;
        int unsigned c;
        int unsigned d;
        pick             = $urandom_range(99);
        w.tone_frequency = 16'($urandom_range(0, 65535));
        w.duration_ms    = 16'($urandom_range(0, 65535));
        if (pick < 5)
        begin
            // well-formed start: a few timer steps per event, a handful of events
            k = $urandom_range(1, 24);
            f = clk_cfg / (2 * k);
            if (f > 65535)
                f = 65535;
            if (f == 0)
                f = 1;
            c = $urandom_range(0, 6);
            d = (c * 500 + f - 1) / f;
            if (d > 65535)
                d = 65535;
            w.kind           = KIND_START;
            w.tone_frequency = 16'(f);
            w.duration_ms    = 16'(d);
        end
        else if (pick < 8)
        begin
            // raw start, sometimes silent
            w.kind = KIND_START;
            if ($urandom_range(7) == 0)
                w.tone_frequency = '0;
        end
        else if (pick < 11)
            w.kind = KIND_STOP;
        else if (pick < 13)
            w.kind = KIND_UNUSED;
        else
            w.kind = KIND_TICK;
        return w;
    endfunction

    // compare every accepted output word with the oldest expectation
    always @(posedge clk)
    begin : check_output
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outputs.size() == 0)
                report_mismatch("output word with nothing expected");
            else
            begin
                want = pending_outputs.pop_front();
                if (out_word.pin_a !== want.pin_a)
                    report_mismatch($sformatf("pin_a got %b want %b",
                                              out_word.pin_a, want.pin_a));
                if (out_word.pin_b !== want.pin_b)
                    report_mismatch($sformatf("pin_b got %b want %b",
                                              out_word.pin_b, want.pin_b));
                if (out_word.playing !== want.playing)
                    report_mismatch($sformatf("playing got %b want %b",
                                              out_word.playing, want.playing));
                if (out_word.start_rejected !== want.start_rejected)
                    report_mismatch($sformatf("start_rejected got %b want %b",
                                              out_word.start_rejected, want.start_rejected));
            end
        end
    end

    initial
    begin : stimulus
        in_word_t w;
        int       n;
        // state after reset
        tone_on    = 1'b0;
        shift_sel  = '0;
        presc_cnt  = '0;
        tmr        = '0;
        tmr_top    = '0;
        events_rem = '0;
        pins       = 2'b00;
        vol_cfg    = VOL_BOTH;
        clk_cfg    = CLOCK_RESET;

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed plan, sender sparse and receiver busy
        idle_tx = 19;
        idle_rx = 59;
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (DIRECTED_PLAN[i].is_reg)
            begin
                settle();
                write_reg(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].reg_val);
            end
            else
                send_word(DIRECTED_PLAN[i].word, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
        end

        // random phases: two with each idling pattern, the last pair without idling
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            write_reg(REG_VOLUME, CFG_DATA_W'(PHASE_VOL[ph]));
            write_reg(REG_CLOCK, CFG_DATA_W'(PHASE_CLOCK[ph]));
            case (ph / 2)
                0:
                begin
                    idle_tx = 19;
                    idle_rx = 59;
                end
                1:
                begin
                    idle_tx = 59;
                    idle_rx = 19;
                end
                default:
                begin
                    idle_tx = 0;
                    idle_rx = 0;
                end
            endcase
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                w = random_word();
                send_word(w, 1'b0, OUT_IDLE);
                // unused kinds leave the block untouched, so they do not count
                if (w.kind != KIND_UNUSED)
                    n++;
            end
        end

        settle();
        if (mismatches == 0)
            $display("[piezo_tone_generator_unit] OK");
        else
            $display("[piezo_tone_generator_unit] ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/ptg_pkg.sv
hw/rtl/ptg_serial_div.sv
hw/rtl/piezo_tone_generator_unit.sv
dv/piezo_tone_generator_unit_test.sv
